// File: rtl/bffm_pkg.sv
package bffm_pkg;

	localparam int POS_W  = 13;
	localparam int IDX_W  = 9;
	localparam int BYTE_W = 8;
	localparam int TYPE_W = 3;
	localparam int STAT_W = 2;

	localparam logic [POS_W-1:0]  BIT_COUNT_RESET = 13'd4096;
	localparam logic [BYTE_W-1:0] BYTE_ONES       = 8'hFF;

	localparam logic [TYPE_W-1:0] REQ_FIND_SET   = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_FIND_CLEAR = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_AND        = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_OR         = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_XOR        = 3'd4;
	localparam logic [TYPE_W-1:0] REQ_READ       = 3'd5;

	localparam logic [STAT_W-1:0] STAT_FOUND  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_AT_END = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NONE   = 2'd2;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic [POS_W-1:0]  start_bit;
		logic [IDX_W-1:0]  byte_index;
		logic [BYTE_W-1:0] mask_byte;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] find_status;
		logic [POS_W-1:0]  bit_position;
		logic [BYTE_W-1:0] read_data;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND,
		ST_MASK,
		ST_DONE
	} state_t;

endpackage

// File: rtl/bitmap_find_first_and_mask.sv
// Bitmap of MAX_BITS bits kept in one synchronous memory of SCAN_WIDTH-bit words. After reset
// a clearing pass writes zero to every word, one word a cycle, and no item is accepted until
// it ends. A find is accepted, then reads one memory word after another from the word holding
// start_bit up to the first hit or the last word in use, then hands over the result once the
// output is free; the one read port streams a word per cycle. A find whose start is at or beyond
// the bits in use (bit_count, capped at MAX_BITS), a read or mask request outside the store, and
// an unknown type go straight from accept to the hand-over. Read and mask requests read one
// word; a mask request on a byte in use then modifies that byte and writes the word back. A new
// item is accepted while the previous result still waits on the output.
module bitmap_find_first_and_mask #(
	parameter int MAX_BITS = 4096,
	parameter int SCAN_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bffm_pkg::POS_W-1:0]    cfg_wdata,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  bffm_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output bffm_pkg::rsp_t                rsp
);

	localparam int LOG_SW      = $clog2(SCAN_WIDTH);
	localparam int WORDS       = (MAX_BITS + SCAN_WIDTH - 1) / SCAN_WIDTH;
	localparam int AW          = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BPW         = SCAN_WIDTH / bffm_pkg::BYTE_W;
	localparam int LANE_W      = (BPW > 1) ? $clog2(BPW) : 1;
	localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
	localparam int PW          = bffm_pkg::POS_W;
	localparam int NBW         = PW - 2;

	bffm_pkg::state_t state_q, state_d;

	logic [PW-1:0]         bit_count_q;
	bffm_pkg::req_t        req_q, req_d;
	logic [AW-1:0]         word_q, word_d;
	logic                  first_q, first_d;
	bffm_pkg::rsp_t        res_q, res_d;
	logic [AW-1:0]         clr_q, clr_d;
	logic                  rsp_valid_q;
	bffm_pkg::rsp_t        rsp_q;
	logic                  out_load;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [SCAN_WIDTH-1:0] rd_data;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [SCAN_WIDTH-1:0] wr_data;

	logic [PW-1:0]         nbits;
	logic [PW-1:0]         nbm1;
	logic [PW:0]           nb_sum;
	logic [NBW-1:0]        nbytes;
	logic [AW-1:0]         last_word;
	logic [LOG_SW-1:0]     tail_lim;
	logic [7:0]            tail8;

	logic                  is_last;
	logic                  f_hit;
	logic [LOG_SW-1:0]     f_pos;

	logic [LANE_W-1:0]     lane;
	logic [NBW-1:0]        idx_ext;
	logic [7:0]            cur_byte;
	logic [7:0]            m_byte;
	logic [7:0]            new_byte;
	logic                  do_write;

	// bits in use and the last word and byte they reach
	always_comb begin
		if (32'(bit_count_q) > MAX_BITS) begin
			nbits = PW'(MAX_BITS);
		end else begin
			nbits = bit_count_q;
		end
		nbm1      = nbits - PW'(1);
		nb_sum    = {1'b0, nbits} + (PW+1)'(7);
		nbytes    = nb_sum[PW:3];
		last_word = AW'(nbm1 >> LOG_SW);
		tail_lim  = nbm1[LOG_SW-1:0];
		if (nbits[2:0] == 3'd0) begin
			tail8 = bffm_pkg::BYTE_ONES;
		end else begin
			tail8 = (8'd1 << nbits[2:0]) - 8'd1;
		end
	end

	bffm_mem #(
		.WORDS(WORDS),
		.SCAN_WIDTH(SCAN_WIDTH)
	) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign is_last = (word_q == last_word);

	bffm_word_find #(
		.SCAN_WIDTH(SCAN_WIDTH)
	) u_find (
		.word(rd_data),
		.invert(req_q.req_type == bffm_pkg::REQ_FIND_CLEAR),
		.use_lo(first_q),
		.lo(req_q.start_bit[LOG_SW-1:0]),
		.use_hi(is_last),
		.hi(tail_lim),
		.hit(f_hit),
		.pos(f_pos)
	);

	// byte lane read-modify-write
	always_comb begin
		lane     = LANE_W'(req_q.byte_index % BPW);
		idx_ext  = NBW'(req_q.byte_index);
		cur_byte = rd_data[lane*bffm_pkg::BYTE_W +: bffm_pkg::BYTE_W];
		m_byte   = req_q.mask_byte;
		if ((idx_ext + NBW'(1)) == nbytes) begin
			m_byte = m_byte & tail8;
		end
		case (req_q.req_type)
			bffm_pkg::REQ_AND: new_byte = cur_byte & m_byte;
			bffm_pkg::REQ_OR:  new_byte = cur_byte | m_byte;
			bffm_pkg::REQ_XOR: new_byte = cur_byte ^ m_byte;
			default:           new_byte = cur_byte;
		endcase
		do_write = (req_q.req_type != bffm_pkg::REQ_READ) && (idx_ext < nbytes);
	end

	always_comb begin
		state_d   = state_q;
		req_d     = req_q;
		word_d    = word_q;
		first_d   = first_q;
		res_d     = res_q;
		clr_d     = clr_q;
		rd_en     = 1'b0;
		rd_addr   = word_q;
		wr_en     = 1'b0;
		wr_addr   = word_q;
		wr_data   = rd_data;
		req_stall = 1'b1;
		out_load  = 1'b0;
		case (state_q)
			bffm_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				clr_d   = clr_q + AW'(1);
				if (clr_q == AW'(WORDS - 1)) begin
					state_d = bffm_pkg::ST_IDLE;
				end
			end
			bffm_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					req_d = req;
					res_d = '0;
					if (req.req_type == bffm_pkg::REQ_FIND_SET ||
					    req.req_type == bffm_pkg::REQ_FIND_CLEAR) begin
						if (req.start_bit == nbits) begin
							res_d.find_status  = bffm_pkg::STAT_AT_END;
							res_d.bit_position = nbits;
							state_d = bffm_pkg::ST_DONE;
						end else if (req.start_bit > nbits) begin
							res_d.find_status = bffm_pkg::STAT_NONE;
							state_d = bffm_pkg::ST_DONE;
						end else begin
							rd_en   = 1'b1;
							rd_addr = AW'(req.start_bit >> LOG_SW);
							word_d  = AW'(req.start_bit >> LOG_SW);
							first_d = 1'b1;
							state_d = bffm_pkg::ST_FIND;
						end
					end else if ((req.req_type == bffm_pkg::REQ_AND ||
					              req.req_type == bffm_pkg::REQ_OR ||
					              req.req_type == bffm_pkg::REQ_XOR ||
					              req.req_type == bffm_pkg::REQ_READ) &&
					             (32'(req.byte_index) < STORE_BYTES)) begin
						rd_en   = 1'b1;
						rd_addr = AW'(req.byte_index / BPW);
						word_d  = AW'(req.byte_index / BPW);
						state_d = bffm_pkg::ST_MASK;
					end else begin
						state_d = bffm_pkg::ST_DONE;
					end
				end
			end
			bffm_pkg::ST_FIND: begin
				if (f_hit) begin
					res_d.find_status  = bffm_pkg::STAT_FOUND;
					res_d.bit_position = PW'({word_q, f_pos});
					state_d = bffm_pkg::ST_DONE;
				end else if (is_last) begin
					res_d.find_status = bffm_pkg::STAT_NONE;
					state_d = bffm_pkg::ST_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = word_q + AW'(1);
					word_d  = word_q + AW'(1);
					first_d = 1'b0;
				end
			end
			bffm_pkg::ST_MASK: begin
				if (do_write) begin
					wr_en = 1'b1;
					wr_data[lane*bffm_pkg::BYTE_W +: bffm_pkg::BYTE_W] = new_byte;
					res_d.read_data = new_byte;
				end else begin
					res_d.read_data = cur_byte;
				end
				state_d = bffm_pkg::ST_DONE;
			end
			bffm_pkg::ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					out_load = 1'b1;
					state_d  = bffm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bffm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bffm_pkg::ST_CLEAR;
			clr_q       <= '0;
			bit_count_q <= bffm_pkg::BIT_COUNT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			if (cfg_we) begin
				bit_count_q <= cfg_wdata;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_q   <= req_d;
		word_q  <= word_d;
		first_q <= first_d;
		res_q   <= res_d;
		if (out_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == bffm_pkg::ST_DONE))
		else $error("result appeared without a finished item");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bffm_pkg::ST_FIND) |-> (word_q <= last_word))
		else $error("find scan ran past the last word in use");

	a_found_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bffm_pkg::ST_FIND && f_hit) |->
		(PW'({word_q, f_pos}) < nbits && PW'({word_q, f_pos}) >= req_q.start_bit))
		else $error("found bit outside the searched range");

	a_no_write_in_find: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bffm_pkg::ST_FIND || state_q == bffm_pkg::ST_DONE) |-> !wr_en)
		else $error("store written outside clear or mask");
`endif

endmodule

// File: rtl/bffm_mem.sv
module bffm_mem #(
	parameter int WORDS = 64,
	parameter int SCAN_WIDTH = 64,
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [SCAN_WIDTH-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [SCAN_WIDTH-1:0] rd_data
);

	logic [SCAN_WIDTH-1:0] mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/bffm_word_find.sv
module bffm_word_find #(
	parameter int SCAN_WIDTH = 64,
	localparam int LW = $clog2(SCAN_WIDTH)
) (
	input  logic [SCAN_WIDTH-1:0] word,
	input  logic                  invert,
	input  logic                  use_lo,
	input  logic [LW-1:0]         lo,
	input  logic                  use_hi,
	input  logic [LW-1:0]         hi,
	output logic                  hit,
	output logic [LW-1:0]         pos
);

	logic [SCAN_WIDTH-1:0] keep;
	logic [SCAN_WIDTH-1:0] cand;

	always_comb begin
		for (int k = 0; k < SCAN_WIDTH; k++) begin
			keep[k] = (!use_lo || (LW'(k) >= lo)) && (!use_hi || (LW'(k) <= hi));
		end
		cand = (word ^ {SCAN_WIDTH{invert}}) & keep;
		hit  = |cand;
		pos  = '0;
		// lowest set bit wins
		for (int k = SCAN_WIDTH - 1; k >= 0; k--) begin
			if (cand[k]) begin
				pos = LW'(k);
			end
		end
	end

endmodule
